### design/mms_pkg.sv
package mms_pkg;

  // Action codes carried by a request transaction.
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_PEEK  = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  // Status codes carried by a response transaction.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_BADIDX   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
    logic [5:0]         depth_index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [6:0]         entry_count;
    logic               is_empty;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
  } rsp_t;

  // Shift controls shared by every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

### design/mms_cell.sv
module mms_cell import mms_pkg::*; #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [WORD_WIDTH-1:0] up_word,
  input  logic [WORD_WIDTH-1:0] up_min,
  input  logic [WORD_WIDTH-1:0] up_max,
  input  logic [WORD_WIDTH-1:0] down_word,
  input  logic [WORD_WIDTH-1:0] down_min,
  input  logic [WORD_WIDTH-1:0] down_max,
  input  logic                  sel,
  output logic [WORD_WIDTH-1:0] word,
  output logic [WORD_WIDTH-1:0] run_min,
  output logic [WORD_WIDTH-1:0] run_max,
  output logic [WORD_WIDTH-1:0] sel_word
);

  // A push moves every entry one place deeper; a pop moves every entry one
  // place toward the top.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      word    <= up_word;
      run_min <= up_min;
      run_max <= up_max;
    end else if (ctrl.pop) begin
      word    <= down_word;
      run_min <= down_min;
      run_max <= down_max;
    end
  end

  assign sel_word = word & {WORD_WIDTH{sel}};

endmodule

### design/min_max_stack.sv
// A request is registered on acceptance; its response is registered once the
// output register is free (rsp_valid low or rsp_ready high).
// No new request is taken while one is in flight; the peek read is an OR tree
// over the cell chain, registered by groups of eight cells on acceptance.
// Reset clears the entry count and the handshake state; cell contents are not
// cleared and are never read above the count.
module min_max_stack import mms_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int WORD_WIDTH  = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CNTW   = $clog2(STACK_DEPTH + 1);
  localparam int GROUPS = (STACK_DEPTH + 7) / 8;

  logic                  busy;
  req_t                  req_q;
  logic [CNTW-1:0]       cnt;
  logic [CNTW-1:0]       cnt_next;
  logic                  fire;
  cell_ctrl_t            ctrl;

  logic [WORD_WIDTH-1:0] cell_word [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] cell_min  [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] cell_max  [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] sel_word  [GROUPS*8];
  logic [WORD_WIDTH-1:0] grp_next  [GROUPS];
  logic [WORD_WIDTH-1:0] grp_q     [GROUPS];
  logic [WORD_WIDTH-1:0] peek_word;

  logic [WORD_WIDTH-1:0] val;
  logic [WORD_WIDTH-1:0] push_min;
  logic [WORD_WIDTH-1:0] push_max;
  logic [WORD_WIDTH-1:0] res;
  logic [WORD_WIDTH-1:0] new_min;
  logic [WORD_WIDTH-1:0] new_max;
  logic [1:0]            status;
  logic                  empty;
  logic                  full;

  assign req_ready = !busy;
  assign fire      = busy && (!rsp_valid || rsp_ready);

  // Incoming word is sign-extended or cut to the internal word width.
  assign val   = WORD_WIDTH'(req_q.value);
  assign empty = (cnt == '0);
  assign full  = (cnt == CNTW'(STACK_DEPTH));

  always_comb begin
    push_min = val;
    push_max = val;
    if (!empty) begin
      if ($signed(cell_min[0]) < $signed(val)) push_min = cell_min[0];
      if ($signed(val) < $signed(cell_max[0])) push_max = cell_max[0];
    end
  end

  genvar i;
  generate
    for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] up_w, up_mn, up_mx, dn_w, dn_mn, dn_mx;
      if (i == 0) begin : g_top
        assign up_w  = val;
        assign up_mn = push_min;
        assign up_mx = push_max;
      end else begin : g_mid
        assign up_w  = cell_word[i-1];
        assign up_mn = cell_min[i-1];
        assign up_mx = cell_max[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
        assign dn_w  = cell_word[i];
        assign dn_mn = cell_min[i];
        assign dn_mx = cell_max[i];
      end else begin : g_inner
        assign dn_w  = cell_word[i+1];
        assign dn_mn = cell_min[i+1];
        assign dn_mx = cell_max[i+1];
      end
      mms_cell #(.WORD_WIDTH(WORD_WIDTH)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .up_word   (up_w),
        .up_min    (up_mn),
        .up_max    (up_mx),
        .down_word (dn_w),
        .down_min  (dn_mn),
        .down_max  (dn_mx),
        .sel       (32'(req.depth_index) == i),
        .word      (cell_word[i]),
        .run_min   (cell_min[i]),
        .run_max   (cell_max[i]),
        .sel_word  (sel_word[i])
      );
    end
    for (i = STACK_DEPTH; i < GROUPS*8; i++) begin : g_pad
      assign sel_word[i] = '0;
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < 8; k++) begin
        grp_next[g] = grp_next[g] | sel_word[g*8 + k];
      end
    end
  end

  always_comb begin
    peek_word = '0;
    for (int g = 0; g < GROUPS; g++) begin
      peek_word = peek_word | grp_q[g];
    end
  end

  always_comb begin
    ctrl     = '0;
    res      = '1;
    status   = ST_OK;
    cnt_next = cnt;
    new_min  = cell_min[0];
    new_max  = cell_max[0];
    case (req_q.action)
      ACT_PUSH: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          ctrl.push = fire;
          res       = val;
          cnt_next  = cnt + CNTW'(1);
          new_min   = push_min;
          new_max   = push_max;
        end
      end
      ACT_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctrl.pop = fire;
          res      = cell_word[0];
          cnt_next = cnt - CNTW'(1);
          new_min  = cell_min[1];
          new_max  = cell_max[1];
        end
      end
      ACT_PEEK: begin
        if (32'(req_q.depth_index) >= 32'(cnt)) begin
          status = ST_BADIDX;
        end else begin
          res = peek_word;
        end
      end
      ACT_QUERY: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          res = cell_word[0];
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    if (cnt_next == '0) begin
      new_min = '1;
      new_max = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (req_valid && req_ready) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
        cnt       <= cnt_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
      grp_q <= grp_next;
    end
    if (fire) begin
      rsp.result_value <= 32'(res);
      rsp.status       <= status;
      rsp.entry_count  <= 7'(cnt_next);
      rsp.is_empty     <= (cnt_next == '0);
      rsp.min_value    <= 32'(new_min);
      rsp.max_value    <= 32'(new_max);
    end
  end

endmodule
